/* rtl/core/hierarchical_tree_lock_manager_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the tree lock manager
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef HIERARCHICAL_TREE_LOCK_MANAGER_TOP_MACROS_SVH
`define HIERARCHICAL_TREE_LOCK_MANAGER_TOP_MACROS_SVH

// same-cycle implication
`define HTLM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("same-cycle check failed");

// next-cycle implication
`define HTLM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`endif

/* rtl/core/htlm_pkg.sv */
// ----------------------------------------------------------------------------
// htlm_pkg
// Types, constants and codes shared by the tree lock manager modules.
// ----------------------------------------------------------------------------
package htlm_pkg;

	localparam int MAX_NODES_DEF    = 1024;
	localparam int USER_ID_BITS_DEF = 16;

	localparam int OPCODE_W     = 2;
	localparam int NODE_INDEX_W = 10;
	localparam int USER_ID_W    = 16;
	localparam int BF_W         = 5;
	localparam int NC_W         = 11;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 11;

	localparam logic [BF_W-1:0] BF_RESET = 5'd2;
	localparam logic [NC_W-1:0] NC_RESET = 11'd1024;

	localparam logic [CFG_IDX_W-1:0] CFG_BRANCHING = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_LOCK    = 2'd0,
		OP_UNLOCK  = 2'd1,
		OP_UPGRADE = 2'd2
	} op_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_NRD,
		S_NEV,
		S_AC_TEST,
		S_AC_DIV,
		S_AC_RD,
		S_AC_EV,
		S_P1_FIRST,
		S_P1_NEXT,
		S_P1_TEST,
		S_P1_RD,
		S_P1_EV,
		S_P2_FIRST,
		S_P2_NEXT,
		S_P2_TEST,
		S_P2_WR,
		S_COMMIT,
		S_AD_TEST,
		S_AD_DIV,
		S_AD_RD,
		S_AD_WR,
		S_OK,
		S_FAIL
	} st_t;

	typedef struct packed {
		logic capture;
		logic rd_node;
		logic anc_init;
		logic div_start;
		logic cur_load;
		logic rd_cur;
		logic lvl_load;
		logic lvl_first;
		logic rd_idx;
		logic found_inc;
		logic idx_inc;
		logic wr_zero_idx;
		logic wr_node;
		logic wr_cur_adj;
		logic clr_init;
		logic clr_wr;
	} cmd_t;

	typedef struct packed {
		logic node_ok;
		logic is_unlock;
		logic is_upgrade;
		logic cur_zero;
		logic div_done;
		logic rd_locked;
		logic owner_ok;
		logic lo_ge_n;
		logic idx_gt_hi;
		logic found_zero;
		logic clr_last;
	} sts_t;

endpackage

/* rtl/core/htlm_div.sv */
// ----------------------------------------------------------------------------
// htlm_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module htlm_div #(
	parameter int W = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [W-1:0]                num,
	input  logic [htlm_pkg::BF_W-1:0]   den,
	output logic                        done,
	output logic [W-1:0]                quo
);

	localparam int CNTW = $clog2(W + 1);
	localparam int RW   = htlm_pkg::BF_W;

	logic            run_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [W-1:0]    num_q;
	logic [RW-1:0]   rem_q;
	logic [W-1:0]    quo_q;

	logic [RW:0]     rs;
	logic [RW:0]     diff;
	logic            ge;
	logic [W:0]      num_sh;
	logic [W:0]      quo_sh;

	assign rs     = {rem_q, num_q[W-1]};
	assign ge     = rs >= {1'b0, den};
	assign diff   = rs - {1'b0, den};
	assign num_sh = {num_q, 1'b0};
	assign quo_sh = {quo_q, ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNTW'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNTW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= num_sh[W-1:0];
			rem_q <= ge ? diff[RW-1:0] : rs[RW-1:0];
			quo_q <= quo_sh[W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* rtl/core/htlm_ctrl.sv */
// ----------------------------------------------------------------------------
// htlm_ctrl
// Request sequencer: node check, ancestor walks, subtree passes, clearing.
// ----------------------------------------------------------------------------
`include "hierarchical_tree_lock_manager_top_macros.svh"

module htlm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            cfg_we,
	input  htlm_pkg::sts_t  sts,
	output htlm_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done,
	output logic            success
);

	htlm_pkg::st_t st_q;
	htlm_pkg::st_t st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= htlm_pkg::S_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			htlm_pkg::S_CLEAR:    if (sts.clr_last) st_d = htlm_pkg::S_IDLE;
			htlm_pkg::S_IDLE:     if (start) st_d = htlm_pkg::S_NRD;
			htlm_pkg::S_NRD:      st_d = htlm_pkg::S_NEV;
			htlm_pkg::S_NEV: begin
				priority if (!sts.node_ok) st_d = htlm_pkg::S_FAIL;
				else if (sts.is_unlock) st_d = htlm_pkg::S_COMMIT;
				else st_d = htlm_pkg::S_AC_TEST;
			end
			htlm_pkg::S_AC_TEST: begin
				priority if (!sts.cur_zero) st_d = htlm_pkg::S_AC_DIV;
				else if (sts.is_upgrade) st_d = htlm_pkg::S_P1_FIRST;
				else st_d = htlm_pkg::S_COMMIT;
			end
			htlm_pkg::S_AC_DIV:   if (sts.div_done) st_d = htlm_pkg::S_AC_RD;
			htlm_pkg::S_AC_RD:    st_d = htlm_pkg::S_AC_EV;
			htlm_pkg::S_AC_EV:
				st_d = sts.rd_locked ? htlm_pkg::S_FAIL : htlm_pkg::S_AC_TEST;
			htlm_pkg::S_P1_FIRST: st_d = htlm_pkg::S_P1_TEST;
			htlm_pkg::S_P1_NEXT:  st_d = htlm_pkg::S_P1_TEST;
			htlm_pkg::S_P1_TEST: begin
				priority if (sts.lo_ge_n)
					st_d = sts.found_zero ? htlm_pkg::S_FAIL : htlm_pkg::S_P2_FIRST;
				else if (sts.idx_gt_hi) st_d = htlm_pkg::S_P1_NEXT;
				else st_d = htlm_pkg::S_P1_RD;
			end
			htlm_pkg::S_P1_RD:    st_d = htlm_pkg::S_P1_EV;
			htlm_pkg::S_P1_EV:
				st_d = sts.owner_ok ? htlm_pkg::S_P1_TEST : htlm_pkg::S_FAIL;
			htlm_pkg::S_P2_FIRST: st_d = htlm_pkg::S_P2_TEST;
			htlm_pkg::S_P2_NEXT:  st_d = htlm_pkg::S_P2_TEST;
			htlm_pkg::S_P2_TEST: begin
				priority if (sts.lo_ge_n) st_d = htlm_pkg::S_COMMIT;
				else if (sts.idx_gt_hi) st_d = htlm_pkg::S_P2_NEXT;
				else st_d = htlm_pkg::S_P2_WR;
			end
			htlm_pkg::S_P2_WR:    st_d = htlm_pkg::S_P2_TEST;
			htlm_pkg::S_COMMIT:   st_d = htlm_pkg::S_AD_TEST;
			htlm_pkg::S_AD_TEST:
				st_d = sts.cur_zero ? htlm_pkg::S_OK : htlm_pkg::S_AD_DIV;
			htlm_pkg::S_AD_DIV:   if (sts.div_done) st_d = htlm_pkg::S_AD_RD;
			htlm_pkg::S_AD_RD:    st_d = htlm_pkg::S_AD_WR;
			htlm_pkg::S_AD_WR:    st_d = htlm_pkg::S_AD_TEST;
			htlm_pkg::S_OK:       st_d = htlm_pkg::S_IDLE;
			htlm_pkg::S_FAIL:     st_d = htlm_pkg::S_IDLE;
			default:              st_d = htlm_pkg::S_CLEAR;
		endcase
		if (cfg_we) st_d = htlm_pkg::S_CLEAR;
	end

	always_comb begin
		cmd          = '0;
		cmd.clr_init = cfg_we;
		unique case (st_q)
			htlm_pkg::S_CLEAR:    cmd.clr_wr = 1'b1;
			htlm_pkg::S_IDLE:     cmd.capture = start && !cfg_we;
			htlm_pkg::S_NRD:      cmd.rd_node = 1'b1;
			htlm_pkg::S_NEV:      cmd.anc_init = 1'b1;
			htlm_pkg::S_AC_TEST,
			htlm_pkg::S_AD_TEST:  cmd.div_start = !sts.cur_zero;
			htlm_pkg::S_AC_DIV,
			htlm_pkg::S_AD_DIV:   cmd.cur_load = sts.div_done;
			htlm_pkg::S_AC_RD,
			htlm_pkg::S_AD_RD:    cmd.rd_cur = 1'b1;
			htlm_pkg::S_P1_FIRST,
			htlm_pkg::S_P2_FIRST: begin
				cmd.lvl_load  = 1'b1;
				cmd.lvl_first = 1'b1;
			end
			htlm_pkg::S_P1_NEXT,
			htlm_pkg::S_P2_NEXT:  cmd.lvl_load = 1'b1;
			htlm_pkg::S_P1_RD:    cmd.rd_idx = 1'b1;
			htlm_pkg::S_P1_EV: begin
				cmd.found_inc = 1'b1;
				cmd.idx_inc   = 1'b1;
			end
			htlm_pkg::S_P2_WR: begin
				cmd.wr_zero_idx = 1'b1;
				cmd.idx_inc     = 1'b1;
			end
			htlm_pkg::S_COMMIT: begin
				cmd.wr_node  = 1'b1;
				cmd.anc_init = 1'b1;
			end
			htlm_pkg::S_AD_WR:    cmd.wr_cur_adj = 1'b1;
			default:              cmd.clr_init = cfg_we;
		endcase
	end

	assign busy    = st_q != htlm_pkg::S_IDLE;
	assign done    = (st_q == htlm_pkg::S_OK) || (st_q == htlm_pkg::S_FAIL);
	assign success = st_q == htlm_pkg::S_OK;

	`HTLM_ASSERT_IMP(a_done_while_busy, done, busy)
	`HTLM_ASSERT_NXT(a_done_single, done, !done)
	`HTLM_ASSERT_NXT(a_accept_reads, start && !busy && !cfg_we, st_q == htlm_pkg::S_NRD)

endmodule

/* rtl/core/htlm_dp.sv */
// ----------------------------------------------------------------------------
// htlm_dp
// Lock state and owner memories, walk registers, parent divider, config.
// ----------------------------------------------------------------------------
module htlm_dp #(
	parameter int MAX_NODES    = htlm_pkg::MAX_NODES_DEF,
	parameter int USER_ID_BITS = htlm_pkg::USER_ID_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [htlm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [htlm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [htlm_pkg::OPCODE_W-1:0]       opcode,
	input  logic [htlm_pkg::NODE_INDEX_W-1:0]   node_index,
	input  logic [htlm_pkg::USER_ID_W-1:0]      user_id,
	input  htlm_pkg::cmd_t                      cmd,
	output htlm_pkg::sts_t                      sts
);

	localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int NW = $clog2(MAX_NODES + 1);
	localparam int XW = (NW > htlm_pkg::NC_W) ? NW : htlm_pkg::NC_W;
	localparam int LW = XW + 6;
	localparam int CW = IW;
	localparam int SW = CW + 1;
	localparam int AW = NW + 2;
	localparam int UW = USER_ID_BITS;

	logic [htlm_pkg::BF_W-1:0] bf_q;
	logic [htlm_pkg::NC_W-1:0] nc_q;
	logic [IW-1:0]             clr_q;

	logic [htlm_pkg::OPCODE_W-1:0] op_q;
	logic                          range_ok_q;
	logic [IW-1:0]                 node_q;
	logic [UW-1:0]                 uid_q;
	logic [IW-1:0]                 cur_q;
	logic [LW-1:0]                 lo_q;
	logic [LW-1:0]                 hi_q;
	logic [LW-1:0]                 idx_q;
	logic [NW-1:0]                 found_q;
	logic [SW-1:0]                 rd_st_q;
	logic [UW-1:0]                 rd_own_q;

	logic [SW-1:0] st_mem [MAX_NODES];
	logic [UW-1:0] own_mem [MAX_NODES];

	logic [htlm_pkg::BF_W-1:0] eff_m;
	logic [XW-1:0]             nc_x;
	logic [XW-1:0]             eff_n;
	logic [XW-1:0]             nidx_x;
	logic [31:0]               uid_x;

	logic                      div_done;
	logic [IW-1:0]             div_quo;

	logic [LW-1:0] src_lo;
	logic [LW-1:0] src_hi;
	logic [LW-1:0] m_l;
	logic [LW-1:0] n_l;
	logic [LW-1:0] nm1;
	logic [LW-1:0] prod_lo;
	logic [LW-1:0] prod_hi;
	logic [LW-1:0] nlo;
	logic [LW-1:0] nhi_raw;
	logic [LW-1:0] nhi;

	logic          rd_locked;
	logic [CW-1:0] rd_cnt;
	logic          own_eq;
	logic          is_unlock;
	logic          is_upgrade;
	logic          node_cond;

	logic [AW-1:0] cnt_x;
	logic [AW-1:0] dec_x;
	logic [AW-1:0] sub_x;
	logic [AW-1:0] sum_x;

	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          st_we;
	logic [IW-1:0] wr_addr;
	logic [SW-1:0] wr_data;
	logic          own_we;

	assign eff_m  = (bf_q == '0) ? htlm_pkg::BF_W'(1) : bf_q;
	assign nc_x   = XW'(nc_q);
	assign eff_n  = (nc_x > XW'(MAX_NODES)) ? XW'(MAX_NODES) : nc_x;
	assign nidx_x = XW'(node_index);
	assign uid_x  = 32'(user_id);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bf_q  <= htlm_pkg::BF_RESET;
			nc_q  <= htlm_pkg::NC_RESET;
			clr_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == htlm_pkg::CFG_BRANCHING) begin
					bf_q <= cfg_data[htlm_pkg::BF_W-1:0];
				end
				if (cfg_index == htlm_pkg::CFG_NODE_COUNT) begin
					nc_q <= cfg_data[htlm_pkg::NC_W-1:0];
				end
			end
			if (cmd.clr_init) begin
				clr_q <= '0;
			end else if (cmd.clr_wr) begin
				clr_q <= clr_q + IW'(1);
			end
		end
	end

	// next subtree level: children span of the current span
	assign src_lo  = cmd.lvl_first ? LW'(node_q) : lo_q;
	assign src_hi  = cmd.lvl_first ? LW'(node_q) : hi_q;
	assign m_l     = LW'(eff_m);
	assign n_l     = LW'(eff_n);
	assign nm1     = n_l - LW'(1);
	assign prod_lo = src_lo * m_l;
	assign prod_hi = src_hi * m_l;
	assign nlo     = prod_lo + LW'(1);
	assign nhi_raw = prod_hi + m_l;
	assign nhi     = (nhi_raw > nm1) ? nm1 : nhi_raw;

	htlm_div #(.W(IW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (cur_q - IW'(1)),
		.den    (eff_m),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= opcode;
			range_ok_q <= nidx_x < eff_n;
			node_q     <= nidx_x[IW-1:0];
			uid_q      <= uid_x[UW-1:0];
			found_q    <= '0;
		end else if (cmd.found_inc && rd_locked) begin
			found_q <= found_q + NW'(1);
		end
		if (cmd.anc_init) begin
			cur_q <= node_q;
		end else if (cmd.cur_load) begin
			cur_q <= div_quo;
		end
		if (cmd.lvl_load) begin
			lo_q  <= nlo;
			hi_q  <= nhi;
			idx_q <= nlo;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + LW'(1);
		end
	end

	assign rd_locked  = rd_st_q[CW];
	assign rd_cnt     = rd_st_q[CW-1:0];
	assign own_eq     = rd_own_q == uid_q;
	assign is_unlock  = op_q == htlm_pkg::OP_UNLOCK;
	assign is_upgrade = op_q == htlm_pkg::OP_UPGRADE;

	always_comb begin
		unique case (op_q)
			htlm_pkg::OP_LOCK:    node_cond = !rd_locked && (rd_cnt == '0);
			htlm_pkg::OP_UNLOCK:  node_cond = rd_locked && own_eq;
			htlm_pkg::OP_UPGRADE: node_cond = !rd_locked && (rd_cnt != '0);
			default:              node_cond = 1'b0;
		endcase
	end

	// ancestor count update: saturating release then lock
	always_comb begin
		cnt_x = AW'(rd_cnt);
		if (is_unlock) begin
			dec_x = AW'(1);
		end else if (is_upgrade) begin
			dec_x = AW'(found_q);
		end else begin
			dec_x = '0;
		end
		sub_x = (cnt_x > dec_x) ? (cnt_x - dec_x) : '0;
		sum_x = is_unlock ? sub_x : (sub_x + AW'(1));
	end

	// memory port steering
	always_comb begin
		rd_en   = cmd.rd_node || cmd.rd_cur || cmd.rd_idx;
		rd_addr = node_q;
		if (cmd.rd_cur) rd_addr = cur_q;
		if (cmd.rd_idx) rd_addr = idx_q[IW-1:0];
		st_we   = 1'b0;
		own_we  = 1'b0;
		wr_addr = node_q;
		wr_data = '0;
		priority if (cmd.clr_wr) begin
			st_we   = 1'b1;
			wr_addr = clr_q;
		end else if (cmd.wr_zero_idx) begin
			st_we   = 1'b1;
			wr_addr = idx_q[IW-1:0];
		end else if (cmd.wr_node) begin
			st_we   = 1'b1;
			own_we  = !is_unlock;
			wr_data = is_unlock ? {1'b0, rd_cnt} : {1'b1, {CW{1'b0}}};
		end else if (cmd.wr_cur_adj) begin
			st_we   = 1'b1;
			wr_addr = cur_q;
			wr_data = {rd_locked, sum_x[CW-1:0]};
		end else begin
			st_we   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[wr_addr] <= wr_data;
		end
		if (own_we) begin
			own_mem[wr_addr] <= uid_q;
		end
		if (rd_en) begin
			rd_st_q  <= st_mem[rd_addr];
			rd_own_q <= own_mem[rd_addr];
		end
	end

	always_comb begin
		sts            = '0;
		sts.node_ok    = range_ok_q && node_cond;
		sts.is_unlock  = is_unlock;
		sts.is_upgrade = is_upgrade;
		sts.cur_zero   = cur_q == '0;
		sts.div_done   = div_done;
		sts.rd_locked  = rd_locked;
		sts.owner_ok   = !rd_locked || own_eq;
		sts.lo_ge_n    = lo_q >= n_l;
		sts.idx_gt_hi  = idx_q > hi_q;
		sts.found_zero = found_q == '0;
		sts.clr_last   = clr_q == IW'(MAX_NODES - 1);
	end

endmodule

/* rtl/core/hierarchical_tree_lock_manager_top.sv */
// ----------------------------------------------------------------------------
// hierarchical_tree_lock_manager_top
// Lock, unlock and upgrade requests over an implicit m-ary tree.
// ----------------------------------------------------------------------------
// One request at a time: raise start while busy is low; the answer appears
// on success with done high for exactly one cycle and cannot be held off.
// Lock and upgrade first walk the ancestors to check them, and every granted
// request walks them again to update their counts; each ancestor step waits
// on the bit-serial parent divider, whose width is IW = clog2(MAX_NODES).
// Upgrade adds an owner check pass and a release pass over the subtree, level
// by level, all through the single read port of the state memory.
// After reset and after every configuration write, a clearing pass over all
// MAX_NODES entries runs with busy high.
// ----------------------------------------------------------------------------
module hierarchical_tree_lock_manager_top #(
	parameter int MAX_NODES    = htlm_pkg::MAX_NODES_DEF,
	parameter int USER_ID_BITS = htlm_pkg::USER_ID_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [htlm_pkg::OPCODE_W-1:0]       opcode,
	input  logic [htlm_pkg::NODE_INDEX_W-1:0]   node_index,
	input  logic [htlm_pkg::USER_ID_W-1:0]      user_id,
	output logic                                done,
	output logic                                success,
	input  logic                                cfg_we,
	input  logic [htlm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [htlm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	htlm_pkg::cmd_t cmd;
	htlm_pkg::sts_t sts;

	htlm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cfg_we  (cfg_we),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.success (success)
	);

	htlm_dp #(
		.MAX_NODES    (MAX_NODES),
		.USER_ID_BITS (USER_ID_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.opcode     (opcode),
		.node_index (node_index),
		.user_id    (user_id),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

/* tb/hierarchical_tree_lock_manager_top_tb.sv */
// ----------------------------------------------------------------------------
// hierarchical_tree_lock_manager_top_tb
// Drives lock, unlock and upgrade requests at the tree lock manager under
// several tree shapes and sender idle rates, predicts each grant from its own
// copy of the lock state, and checks every answer in order as it arrives.
// ----------------------------------------------------------------------------
module hierarchical_tree_lock_manager_top_tb;

	localparam int NODES = htlm_pkg::MAX_NODES_DEF;
	localparam int OW    = htlm_pkg::OPCODE_W;
	localparam int NIW   = htlm_pkg::NODE_INDEX_W;
	localparam int UIW   = htlm_pkg::USER_ID_W;
	localparam int DW    = htlm_pkg::CFG_DATA_W;
	localparam logic [OW-1:0] OP_BAD = 2'd3;
	localparam int STALL_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [OW-1:0] opcode = '0;
	logic [NIW-1:0] node_index = '0;
	logic [UIW-1:0] user_id = '0;
	logic cfg_we = 1'b0;
	logic [htlm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [DW-1:0] cfg_data = '0;
	logic busy, done, success;

	hierarchical_tree_lock_manager_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .node_index(node_index), .user_id(user_id),
		.done(done), .success(success),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// lock state mirror
	bit held[NODES];
	logic [UIW-1:0] holder[NODES];
	int unsigned below[NODES];
	logic [htlm_pkg::BF_W-1:0] fanout_reg = htlm_pkg::BF_RESET;
	logic [htlm_pkg::NC_W-1:0] count_reg = htlm_pkg::NC_RESET;

	bit grant_queue[$];
	int errors = 0;
	int idle_pct = 0;
	int quiet_cycles = 0;

	function automatic int unsigned fanout();
		return (fanout_reg == 0) ? 1 : 32'(fanout_reg);
	endfunction

	function automatic int unsigned live_nodes();
		return (count_reg > NODES) ? NODES : 32'(count_reg);
	endfunction

	function automatic bit ancestor_held(int unsigned nd);
		while (nd != 0) begin
			nd = (nd - 1) / fanout();
			if (held[nd]) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void bump_ancestors(int unsigned nd, bit up);
		while (nd != 0) begin
			nd = (nd - 1) / fanout();
			if (up) below[nd]++;
			else if (below[nd] != 0) below[nd]--;
		end
	endfunction

	function automatic bit grant_lock(int unsigned nd, logic [UIW-1:0] uid);
		if (held[nd] || below[nd] != 0 || ancestor_held(nd)) return 1'b0;
		held[nd] = 1'b1;
		holder[nd] = uid;
		bump_ancestors(nd, 1'b1);
		return 1'b1;
	endfunction

	function automatic bit grant_upgrade(int unsigned nd, logic [UIW-1:0] uid);
		int unsigned walk[$];
		int unsigned pos, cur, c, first, owned;
		if (held[nd] || below[nd] == 0 || ancestor_held(nd)) return 1'b0;
		owned = 0;
		pos = 0;
		walk.insert(walk.size(), nd);
		while (pos < walk.size()) begin
			cur = walk[pos];
			pos++;
			first = cur * fanout() + 1;
			for (c = first; c < first + fanout() && c < live_nodes(); c++) begin
				if (held[c]) begin
					if (holder[c] != uid) return 1'b0;
					owned++;
				end
				if (held[c] || below[c] != 0) walk.insert(walk.size(), c);
			end
		end
		if (owned == 0) return 1'b0;
		for (int k = 1; k < walk.size(); k++) begin
			if (held[walk[k]]) begin
				held[walk[k]] = 1'b0;
				bump_ancestors(walk[k], 1'b0);
			end
		end
		return grant_lock(nd, uid);
	endfunction

	function automatic bit predict_grant(logic [OW-1:0] op, int unsigned nd,
			logic [UIW-1:0] uid);
		if (nd >= live_nodes()) return 1'b0;
		unique case (op)
			htlm_pkg::OP_LOCK: return grant_lock(nd, uid);
			htlm_pkg::OP_UNLOCK: begin
				if (!held[nd] || holder[nd] != uid) return 1'b0;
				held[nd] = 1'b0;
				bump_ancestors(nd, 1'b0);
				return 1'b1;
			end
			htlm_pkg::OP_UPGRADE: return grant_upgrade(nd, uid);
			default: return 1'b0;
		endcase
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_request(logic [OW-1:0] op, logic [NIW-1:0] nd,
			logic [UIW-1:0] uid);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		opcode = op;
		node_index = nd;
		user_id = uid;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		grant_queue.insert(grant_queue.size(), predict_grant(op, 32'(nd), uid));
		@(negedge clk);
	endtask

	task automatic drain();
		start = 1'b0;
		while (grant_queue.size() != 0 || busy) @(negedge clk);
	endtask

	task automatic write_reg(logic [htlm_pkg::CFG_IDX_W-1:0] idx, logic [DW-1:0] val);
		drain();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == htlm_pkg::CFG_BRANCHING) fanout_reg = val[htlm_pkg::BF_W-1:0];
		else count_reg = val[htlm_pkg::NC_W-1:0];
		for (int i = 0; i < NODES; i++) begin
			held[i] = 1'b0;
			below[i] = 0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (grant_queue.size() == 0) begin
				$display("%0t unexpected result: expected none actual %0b", $time, success);
				errors++;
			end else if (success !== grant_queue[0]) begin
				$display("%0t success mismatch: expected %0b actual %0b", $time,
					grant_queue[0], success);
				errors++;
				void'(grant_queue.pop_front());
			end else begin
				void'(grant_queue.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic test_reset_shape();
		send_request(htlm_pkg::OP_LOCK, 10'd1023, 16'hFFFF);
		send_request(htlm_pkg::OP_LOCK, 10'd0, 16'h0000);
		send_request(htlm_pkg::OP_LOCK, 10'd511, 16'h0000);
		send_request(htlm_pkg::OP_UNLOCK, 10'd1023, 16'h0000);
		send_request(htlm_pkg::OP_UPGRADE, 10'd1023, 16'hFFFF);
		send_request(htlm_pkg::OP_LOCK, 10'd1021, 16'hFFFF);
		send_request(htlm_pkg::OP_LOCK, 10'd1022, 16'h0001);
		send_request(htlm_pkg::OP_UPGRADE, 10'd510, 16'hFFFF);
		send_request(htlm_pkg::OP_UNLOCK, 10'd1022, 16'h0001);
		send_request(htlm_pkg::OP_UPGRADE, 10'd510, 16'hFFFF);
		send_request(htlm_pkg::OP_UPGRADE, 10'd255, 16'hFFFF);
		send_request(htlm_pkg::OP_UPGRADE, 10'd0, 16'hFFFF);
		send_request(htlm_pkg::OP_LOCK, 10'd5, 16'h0000);
		send_request(htlm_pkg::OP_UPGRADE, 10'd1, 16'h0000);
		send_request(htlm_pkg::OP_UNLOCK, 10'd0, 16'hFFFF);
		send_request(htlm_pkg::OP_UPGRADE, 10'd0, 16'h0000);
		send_request(OP_BAD, 10'd0, 16'h0000);
		send_request(htlm_pkg::OP_LOCK, 10'd0, 16'h0000);
		send_request(htlm_pkg::OP_UNLOCK, 10'd0, 16'h0000);
	endtask

	task automatic test_odd_config();
		write_reg(htlm_pkg::CFG_BRANCHING, 11'd0);
		write_reg(htlm_pkg::CFG_NODE_COUNT, 11'd5);
		send_request(htlm_pkg::OP_LOCK, 10'd4, 16'h00AA);
		send_request(htlm_pkg::OP_LOCK, 10'd5, 16'h00AA);
		send_request(htlm_pkg::OP_LOCK, 10'd1023, 16'h00AA);
		send_request(htlm_pkg::OP_UPGRADE, 10'd0, 16'h00AA);
		send_request(OP_BAD, 10'd1, 16'h00AA);
		write_reg(htlm_pkg::CFG_NODE_COUNT, 11'd0);
		send_request(htlm_pkg::OP_LOCK, 10'd0, 16'h0000);
		send_request(htlm_pkg::OP_UPGRADE, 10'd0, 16'h0000);
		write_reg(htlm_pkg::CFG_BRANCHING, 11'h7FF);
		write_reg(htlm_pkg::CFG_NODE_COUNT, 11'h7FF);
		send_request(htlm_pkg::OP_LOCK, 10'd1023, 16'h5555);
		send_request(htlm_pkg::OP_UPGRADE, 10'd0, 16'h5555);
	endtask

	task automatic random_phase(int unsigned bf, int unsigned nc, int items, int pct);
		logic [OW-1:0] op;
		logic [NIW-1:0] nd;
		logic [UIW-1:0] uid;
		int unsigned roll;
		write_reg(htlm_pkg::CFG_BRANCHING, DW'(bf));
		write_reg(htlm_pkg::CFG_NODE_COUNT, DW'(nc));
		idle_pct = pct;
		for (int i = 0; i < items; i++) begin
			roll = $urandom_range(99);
			if (roll < 45) op = htlm_pkg::OP_LOCK;
			else if (roll < 70) op = htlm_pkg::OP_UNLOCK;
			else if (roll < 95) op = htlm_pkg::OP_UPGRADE;
			else op = OP_BAD;
			if (live_nodes() == 0 || $urandom_range(99) < 5) nd = NIW'($urandom);
			else nd = NIW'($urandom_range(live_nodes() - 1));
			if ($urandom_range(99) < 4) uid = UIW'($urandom);
			else uid = UIW'($urandom_range(2));
			send_request(op, nd, uid);
			if (i == items / 2) drain();
		end
		idle_pct = 0;
	endtask

	task automatic test_random_shapes();
		random_phase(2, 1024, 160, 0);
		random_phase(1, 40, 150, 46);
		random_phase(16, 300, 150, 30);
		random_phase(0, 20, 120, 0);
		random_phase(31, 1024, 130, 46);
		random_phase(3, 2047, 150, 30);
		random_phase(2, 1, 50, 0);
		random_phase(4, 0, 40, 46);
		random_phase(2, 63, 200, 30);
		random_phase(5, 160, 120, 0);
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_reset_shape();
		test_odd_config();
		test_random_shapes();
		drain();
		repeat (50) @(negedge clk);
		if (errors == 0 && grant_queue.size() == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/htlm_pkg.sv
rtl/core/htlm_div.sv
rtl/core/htlm_ctrl.sv
rtl/core/htlm_dp.sv
rtl/core/hierarchical_tree_lock_manager_top.sv
tb/hierarchical_tree_lock_manager_top_tb.sv
